/* hdl/bilinear_downscale_normalize_macros.svh */
// assertion macros shared by the downscale blocks
// no dependencies; included by the modules that check themselves
`ifndef BILINEAR_DOWNSCALE_NORMALIZE_MACROS_SVH
`define BILINEAR_DOWNSCALE_NORMALIZE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define BDN_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define BDN_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bdn_pkg.sv */
// types and constants of the bilinear downscale and normalise block
// no dependencies; imported by every module of the block
package bdn_pkg;

    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int PIX_W   = NUM_CH * CH_W;
    localparam int POS_W   = 7;
    localparam int WT_W    = 4;
    localparam int WPROD_W = 8;
    localparam int PROD_W  = CH_W + WPROD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int RECIP_W = 31;
    localparam int RECIP_SH = 31;
    localparam int MQ_W    = SUM_W + RECIP_W;
    localparam int QUO_W   = 16;
    localparam int OUT_W   = 16;
    localparam int Q_DEPTH_DEF = 4;

    // raster positions
    localparam logic [POS_W-1:0] SRC_LAST = 7'd127;
    localparam logic [POS_W-1:0] DST_LAST = 7'd111;

    // tap tracking: right tap (16k+1)/14+1 and weight (16k+1) mod 14
    localparam logic [POS_W-1:0] TAP_INIT    = 7'd1;
    localparam logic [POS_W-1:0] TAP_STEP_LO = 7'd1;
    localparam logic [POS_W-1:0] TAP_STEP_HI = 7'd2;
    localparam logic [WT_W-1:0]  WT_INIT     = 4'd1;
    localparam logic [WT_W-1:0]  WT_FULL     = 4'd14;
    localparam logic [WT_W:0]    WT_STEP     = 5'd2;
    localparam logic [WT_W:0]    WT_MOD      = 5'd14;

    // q = floor((16384*S + 12495) / 24990) = (S*RECIP_M + 2^30) >> 31,
    // exact for every tap sum S up to 255*196; result q - 16384
    localparam logic [RECIP_W-1:0] RECIP_M   = 31'd1407938059;
    localparam logic [MQ_W-1:0]    RECIP_RND = 49'd1073741824;
    localparam logic [QUO_W-1:0]   QUO_FULL  = 16'd32768;
    localparam logic [QUO_W-1:0]   OUT_BIAS  = 16'd16384;

    // red in the lowest byte
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    // one output pixel with its four taps and weights
    typedef struct packed {
        t_rgb                p00;
        t_rgb                p01;
        t_rgb                p10;
        t_rgb                p11;
        logic [WPROD_W-1:0]  w00;
        logic [WPROD_W-1:0]  w01;
        logic [WPROD_W-1:0]  w10;
        logic [WPROD_W-1:0]  w11;
        logic [POS_W-1:0]    col;
        logic [POS_W-1:0]    row;
        logic                fe;
    } t_tap_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // packed in tdata order, red lowest
    typedef struct packed {
        logic [POS_W-1:0]        row;
        logic [POS_W-1:0]        col;
        logic signed [OUT_W-1:0] blue;
        logic signed [OUT_W-1:0] green;
        logic signed [OUT_W-1:0] red;
    } t_out_pix;

endpackage

/* hdl/bdn_front.sv */
// front end: raster tracking, line store, tap gathering and output scheduling
// depends on bdn_pkg and the assertion macro header
`include "bilinear_downscale_normalize_macros.svh"

module bdn_front import bdn_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_tvalid,
    output logic            o_tready,
    input  t_rgb            i_tdata,
    input  logic            i_tuser,
    output logic            o_push,
    output t_tap_rec        o_rec,
    input  t_q_stat         i_qstat
);

    logic [PIX_W-1:0] r_line_mem [2**POS_W];
    logic [PIX_W-1:0] r_mem_rd;
    logic             r_byp;
    t_rgb             r_byp_pix;

    logic [POS_W-1:0] r_src_col, r_src_row, r_ocol, r_orow, r_tapc, r_tapr;
    logic [WT_W-1:0]  r_wc, r_wr;
    logic [POS_W-1:0] n_src_col, n_src_row, n_ocol, n_orow, n_tapc, n_tapr;
    logic [WT_W-1:0]  n_wc, n_wr;

    logic [POS_W-1:0] b_col, b_row, b_ocol, b_orow, b_tapc, b_tapr;
    logic [WT_W-1:0]  b_wc, b_wr;
    logic [WT_W:0]    wc2, wr2;
    logic             wc_wrap, wr_wrap;
    logic [WT_W-1:0]  step_wc, step_wr;
    logic [POS_W-1:0] step_tapc, step_tapr;
    logic             emit, accept, s1_done;

    logic             r_s1_vld;
    t_rgb             r_s1_pix;
    logic [POS_W-1:0] r_s1_col, r_s1_ocol, r_s1_orow;
    logic             r_s1_emit, r_s1_fe;
    logic [WT_W-1:0]  r_s1_a, r_s1_b;
    t_rgb             r_left, r_upleft;
    t_rgb             above;
    logic [WT_W-1:0]  wa_n, wb_n;

    assign s1_done  = r_s1_vld && (!r_s1_emit || !i_qstat.full);
    assign o_tready = !r_s1_vld || s1_done;
    assign accept   = i_tvalid && o_tready;

    // position of this beat, frame start forces the origin
    always_comb begin
        b_col  = i_tuser ? '0 : r_src_col;
        b_row  = i_tuser ? '0 : r_src_row;
        b_ocol = i_tuser ? '0 : r_ocol;
        b_orow = i_tuser ? '0 : r_orow;
        b_tapc = i_tuser ? TAP_INIT : r_tapc;
        b_tapr = i_tuser ? TAP_INIT : r_tapr;
        b_wc   = i_tuser ? WT_INIT : r_wc;
        b_wr   = i_tuser ? WT_INIT : r_wr;
        emit   = (b_col == b_tapc) && (b_row == b_tapr);

        wc2       = {1'b0, b_wc} + WT_STEP;
        wc_wrap   = wc2 >= WT_MOD;
        step_wc   = wc_wrap ? WT_W'(wc2 - WT_MOD) : wc2[WT_W-1:0];
        step_tapc = b_tapc + (wc_wrap ? TAP_STEP_HI : TAP_STEP_LO);
        wr2       = {1'b0, b_wr} + WT_STEP;
        wr_wrap   = wr2 >= WT_MOD;
        step_wr   = wr_wrap ? WT_W'(wr2 - WT_MOD) : wr2[WT_W-1:0];
        step_tapr = b_tapr + (wr_wrap ? TAP_STEP_HI : TAP_STEP_LO);
    end

    always_comb begin
        n_src_col = r_src_col;
        n_src_row = r_src_row;
        n_ocol    = r_ocol;
        n_orow    = r_orow;
        n_tapc    = r_tapc;
        n_tapr    = r_tapr;
        n_wc      = r_wc;
        n_wr      = r_wr;
        if (accept) begin
            n_src_col = b_col + 1'b1;
            n_src_row = (b_col == SRC_LAST) ? b_row + 1'b1 : b_row;
            n_ocol    = b_ocol;
            n_orow    = b_orow;
            n_tapc    = b_tapc;
            n_tapr    = b_tapr;
            n_wc      = b_wc;
            n_wr      = b_wr;
            if (emit) begin
                if (b_ocol == DST_LAST) begin
                    n_ocol = '0;
                    n_tapc = TAP_INIT;
                    n_wc   = WT_INIT;
                    if (b_orow == DST_LAST) begin
                        n_orow = '0;
                        n_tapr = TAP_INIT;
                        n_wr   = WT_INIT;
                    end else begin
                        n_orow = b_orow + 1'b1;
                        n_tapr = step_tapr;
                        n_wr   = step_wr;
                    end
                end else begin
                    n_ocol = b_ocol + 1'b1;
                    n_tapc = step_tapc;
                    n_wc   = step_wc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col <= '0;
            r_src_row <= '0;
            r_ocol    <= '0;
            r_orow    <= '0;
            r_tapc    <= TAP_INIT;
            r_tapr    <= TAP_INIT;
            r_wc      <= WT_INIT;
            r_wr      <= WT_INIT;
            r_s1_vld  <= 1'b0;
            r_left    <= '0;
            r_upleft  <= '0;
        end else begin
            r_src_col <= n_src_col;
            r_src_row <= n_src_row;
            r_ocol    <= n_ocol;
            r_orow    <= n_orow;
            r_tapc    <= n_tapc;
            r_tapr    <= n_tapr;
            r_wc      <= n_wc;
            r_wr      <= n_wr;
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_done) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_done) begin
                r_left   <= r_s1_pix;
                r_upleft <= above;
            end
        end
    end

    // line store, written as the held beat leaves, read as the next one enters
    always_ff @(posedge i_clk) begin
        if (s1_done) begin
            r_line_mem[r_s1_col] <= r_s1_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_rd <= r_line_mem[b_col];
        end
    end

    // same-column write in the read cycle, only after an early frame restart
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp     <= s1_done && (r_s1_col == b_col);
            r_byp_pix <= r_s1_pix;
            r_s1_pix  <= i_tdata;
            r_s1_col  <= b_col;
            r_s1_emit <= emit;
            r_s1_a    <= b_wc;
            r_s1_b    <= b_wr;
            r_s1_ocol <= b_ocol;
            r_s1_orow <= b_orow;
            r_s1_fe   <= (b_ocol == DST_LAST) && (b_orow == DST_LAST);
        end
    end

    assign above = r_byp ? r_byp_pix : t_rgb'(r_mem_rd);
    assign wa_n  = WT_FULL - r_s1_a;
    assign wb_n  = WT_FULL - r_s1_b;
    assign o_push = s1_done && r_s1_emit;

    always_comb begin
        o_rec.p00 = r_upleft;
        o_rec.p01 = above;
        o_rec.p10 = r_left;
        o_rec.p11 = r_s1_pix;
        o_rec.w00 = {4'b0, wa_n} * {4'b0, wb_n};
        o_rec.w01 = {4'b0, r_s1_a} * {4'b0, wb_n};
        o_rec.w10 = {4'b0, wa_n} * {4'b0, r_s1_b};
        o_rec.w11 = {4'b0, r_s1_a} * {4'b0, r_s1_b};
        o_rec.col = r_s1_ocol;
        o_rec.row = r_s1_orow;
        o_rec.fe  = r_s1_fe;
    end

    // an output never lands on the first source column, so the left tap is real
    `BDN_ASSERT_SAME(a_emit_not_col0, i_clk, i_rst_n, r_s1_vld && r_s1_emit, r_s1_col != '0, "output scheduled on source column zero")

endmodule

/* hdl/bdn_queue.sv */
// short record queue between the front end and the arithmetic back end
// depends on bdn_pkg and the assertion macro header
`include "bilinear_downscale_normalize_macros.svh"

module bdn_queue import bdn_pkg::*; #(
    parameter int DEPTH = Q_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_tap_rec i_rec,
    input  logic     i_pop,
    output t_tap_rec o_rec,
    output t_q_stat  o_stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_tap_rec      r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    assign o_rec       = r_mem[r_rd];
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.empty = (r_count == '0);

    `BDN_ASSERT_NEXT(a_fill_up, i_clk, i_rst_n, i_push && !i_pop, r_count == $past(r_count) + CW'(1), "queue fill count lost a push")
    `BDN_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from an empty queue")

endmodule

/* hdl/bdn_back.sv */
// back end: tap weighting, reciprocal-multiply normalisation and output register
// depends on bdn_pkg and the assertion macro header
`include "bilinear_downscale_normalize_macros.svh"

module bdn_back import bdn_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_tap_rec i_rec,
    input  t_q_stat  i_qstat,
    output logic     o_pop,
    output logic     o_tvalid,
    input  logic     i_tready,
    output t_out_pix o_pix,
    output logic     o_fe
);

    logic adv;

    // product stage
    logic              r_m_vld;
    logic [PROD_W-1:0] r_m_prod [NUM_CH][4];
    logic [POS_W-1:0]  r_m_col, r_m_row;
    logic              r_m_fe;

    // tap sum stage
    logic              r_s_vld;
    logic [SUM_W-1:0]  r_s_sum [NUM_CH];
    logic [POS_W-1:0]  r_s_col, r_s_row;
    logic              r_s_fe;

    // reciprocal product stage
    logic              r_p_vld;
    logic [MQ_W-1:0]   r_p_prod [NUM_CH];
    logic [POS_W-1:0]  r_p_col, r_p_row;
    logic              r_p_fe;

    logic [SUM_W-1:0]  sum [NUM_CH];
    logic [MQ_W-1:0]   rnd [NUM_CH];
    logic [QUO_W-1:0]  quo [NUM_CH];

    logic              r_out_vld;
    t_out_pix          r_out_pix;
    logic              r_out_fe;

    assign adv   = !r_out_vld || i_tready;
    assign o_pop = adv && !i_qstat.empty;

    always_comb begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
            sum[ch] = SUM_W'(r_m_prod[ch][0]) + SUM_W'(r_m_prod[ch][1])
                    + SUM_W'(r_m_prod[ch][2]) + SUM_W'(r_m_prod[ch][3]);
            // rounding bit, then the top bits are the quotient
            rnd[ch] = r_p_prod[ch] + RECIP_RND;
            quo[ch] = rnd[ch][RECIP_SH +: QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld   <= 1'b0;
            r_s_vld   <= 1'b0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_m_vld   <= o_pop;
            r_s_vld   <= r_m_vld;
            r_p_vld   <= r_s_vld;
            r_out_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_m_prod[ch][0] <= {8'b0, i_rec.p00[CH_W*ch +: CH_W]} * {8'b0, i_rec.w00};
                r_m_prod[ch][1] <= {8'b0, i_rec.p01[CH_W*ch +: CH_W]} * {8'b0, i_rec.w01};
                r_m_prod[ch][2] <= {8'b0, i_rec.p10[CH_W*ch +: CH_W]} * {8'b0, i_rec.w10};
                r_m_prod[ch][3] <= {8'b0, i_rec.p11[CH_W*ch +: CH_W]} * {8'b0, i_rec.w11};
            end
            r_m_col <= i_rec.col;
            r_m_row <= i_rec.row;
            r_m_fe  <= i_rec.fe;

            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_s_sum[ch] <= sum[ch];
            end
            r_s_col <= r_m_col;
            r_s_row <= r_m_row;
            r_s_fe  <= r_m_fe;

            for (int ch = 0; ch < NUM_CH; ch++) begin
                r_p_prod[ch] <= MQ_W'(r_s_sum[ch]) * MQ_W'(RECIP_M);
            end
            r_p_col <= r_s_col;
            r_p_row <= r_s_row;
            r_p_fe  <= r_s_fe;

            r_out_pix.red   <= signed'(quo[0] - OUT_BIAS);
            r_out_pix.green <= signed'(quo[1] - OUT_BIAS);
            r_out_pix.blue  <= signed'(quo[2] - OUT_BIAS);
            r_out_pix.col   <= r_p_col;
            r_out_pix.row   <= r_p_row;
            r_out_fe        <= r_p_fe;
        end
    end

    assign o_tvalid = r_out_vld;
    assign o_pix    = r_out_pix;
    assign o_fe     = r_out_fe;

    // the normalised value never exceeds one
    `BDN_ASSERT_SAME(a_quo_max, i_clk, i_rst_n, r_p_vld, quo[0] <= QUO_FULL && quo[1] <= QUO_FULL && quo[2] <= QUO_FULL, "quotient above full scale")
    `BDN_ASSERT_SAME(a_last_pos, i_clk, i_rst_n, r_out_vld && r_out_fe, r_out_pix.col == DST_LAST && r_out_pix.row == DST_LAST, "frame end away from the last output position")
    `BDN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_vld && !i_tready, r_out_vld && $stable(r_out_pix), "result beat changed while stalled")

endmodule

/* hdl/bilinear_downscale_normalize.sv */
// path: front stage register, queue, then product, sum, reciprocal and output registers
// throughput: one source beat per cycle; the back pipeline (multiply, add, reciprocal
//   multiply, output register) takes one record per cycle while the sink is ready, so
//   input stalls only when a held-off sink fills the queue behind a beat completing a pixel
// reset: i_rst_n synchronous active low, clears raster and output counters, valid
//   flags and queue pointers; the line store is not cleared and needs no clearing pass
module bilinear_downscale_normalize import bdn_pkg::*; #(
    parameter int Q_DEPTH = Q_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // source pixel stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
    input  logic        s_axis_tuser,   // frame_start
    // downscaled, normalised pixel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_red, out_green, out_blue, out_col, out_row
    output logic        m_axis_tlast    // frame_end
);

    // front to queue
    logic     push;
    t_tap_rec push_rec;
    t_q_stat  qstat;

    // queue to back
    logic     pop;
    t_tap_rec pop_rec;

    t_out_pix out_pix;

    // front end: tracks the raster position, keeps the previous source row and
    // pixel, and decides which beat completes the four taps of an output pixel
    bdn_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (t_rgb'(s_axis_tdata)),
        .i_tuser  (s_axis_tuser),
        .o_push   (push),
        .o_rec    (push_rec),
        .i_qstat  (qstat)
    );

    // decouples the two halves, so a stalled sink holds the front end only once the queue is full
    bdn_queue #(
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_rec   (pop_rec),
        .o_stat  (qstat)
    );

    // back end: weighted tap sum, exact scaling to q2.14 and the output register
    bdn_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rec    (pop_rec),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_pix    (out_pix),
        .o_fe     (m_axis_tlast)
    );

    // top two bits pad the beat to whole bytes
    assign m_axis_tdata = {2'b00, out_pix};

endmodule
